>>> hw/rtl/ecmp_next_hop_select_unit_macros.svh
// ----------------------------------------------------------------------------
// ECMP next-hop select assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ECMP_NEXT_HOP_SELECT_UNIT_MACROS_SVH
`define ECMP_NEXT_HOP_SELECT_UNIT_MACROS_SVH

`ifndef SYNTH
// ante implies cons in the same cycle (cons may open with a ## delay)
`define ECMP_ASSERT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> cons) \
    else $error("ecmp assertion failed");
// ante implies cons in the next cycle
`define ECMP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ecmp assertion failed");
`else
`define ECMP_ASSERT(lbl, ck, rs, ante, cons)
`define ECMP_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

>>> hw/rtl/ecmp_pkg.sv
// ----------------------------------------------------------------------------
// ECMP package
// Shared types and constants of the ECMP next-hop select unit.
// ----------------------------------------------------------------------------
package ecmp_pkg;

  // MurmurHash3 x86_32 constants
  localparam logic [31:0] MUR_C1     = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2     = 32'h1b873593;
  localparam logic [31:0] MUR_N      = 32'he6546b64;
  localparam logic [31:0] FMIX_C1    = 32'h85ebca6b;
  localparam logic [31:0] FMIX_C2    = 32'hc2b2ae35;
  localparam logic [31:0] KEY_BYTES  = 32'd12;

  localparam int HASH_LAT    = 8;
  localparam int MOD_STAGES  = 4;
  localparam int MOD_BITS    = 32 / MOD_STAGES;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_LOOKUP   = 2'd0,
    CMD_SLOT_WR  = 2'd1,
    CMD_COUNT_WR = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_LOADED = 3'd1,
    ST_RANGE      = 3'd2,
    ST_SAME_NODE  = 3'd3,
    ST_NO_ROUTE   = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t        kind;
    status_t     status;
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [2:0]  slot;
    logic [7:0]  iface;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [3:0]  count;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] seed;
  } fe_item_t;

endpackage

>>> hw/rtl/ecmp_next_hop_select_unit.sv
// ----------------------------------------------------------------------------
// ECMP next-hop select unit
// Route table lookup with MurmurHash3 flow hashing across equal-cost hops.
// ----------------------------------------------------------------------------
//  channel  | handshake            | ports
//  ---------+----------------------+-------------------------------------------
//  command  | start & !busy        | cmd, from_node .. hop_count
//  result   | done strobe, 1 cycle | out_interface, status
//  config   | cfg_we               | cfg_wdata (topo_size)
//
//  One item per clock while busy is low. A taken item passes through the
//  queue stage, the hash multiplier pipeline, the modulo stages and the
//  registered slot table read before its result comes out.
//  After reset the hop counts are cleared, one row per cycle, over all
//  2**(2*clog2(NODES)) rows (256 at the defaults); busy is high meanwhile.
//  The result side has no backpressure, so busy is otherwise low.
// ----------------------------------------------------------------------------
module ecmp_next_hop_select_unit #(
  parameter int NODES = 16,
  parameter int WAYS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic [1:0]  cmd,
  input  logic [3:0]  from_node,
  input  logic [3:0]  to_node,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [15:0] flow_sport,
  input  logic [15:0] flow_dport,
  input  logic [31:0] seed,
  input  logic [2:0]  slot,
  input  logic [7:0]  hop_interface,
  input  logic [3:0]  hop_count,
  output logic        done,
  output logic [7:0]  out_interface,
  output logic [2:0]  status
);
  import ecmp_pkg::*;

  logic     push;
  fe_item_t item;
  logic     q_full;
  logic     head_valid;
  fe_item_t head;
  logic     clearing;

  assign busy = q_full || clearing;

  ecmp_front #(
    .NODES (NODES),
    .WAYS  (WAYS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .from_node     (from_node),
    .to_node       (to_node),
    .src_ip        (src_ip),
    .dst_ip        (dst_ip),
    .flow_sport    (flow_sport),
    .flow_dport    (flow_dport),
    .seed          (seed),
    .slot          (slot),
    .hop_interface (hop_interface),
    .hop_count     (hop_count),
    .push          (push),
    .item          (item)
  );

  ecmp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  ecmp_back #(
    .NODES (NODES),
    .WAYS  (WAYS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .clearing      (clearing),
    .done          (done),
    .out_interface (out_interface),
    .status        (status)
  );

endmodule

>>> hw/rtl/ecmp_front.sv
// ----------------------------------------------------------------------------
// ECMP front end
// Holds the node count register, accepts items and classifies them.
// ----------------------------------------------------------------------------
module ecmp_front #(
  parameter int NODES = 16,
  parameter int WAYS  = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic [1:0]         cmd,
  input  logic [3:0]         from_node,
  input  logic [3:0]         to_node,
  input  logic [31:0]        src_ip,
  input  logic [31:0]        dst_ip,
  input  logic [15:0]        flow_sport,
  input  logic [15:0]        flow_dport,
  input  logic [31:0]        seed,
  input  logic [2:0]         slot,
  input  logic [7:0]         hop_interface,
  input  logic [3:0]         hop_count,
  output logic               push,
  output ecmp_pkg::fe_item_t item
);
  import ecmp_pkg::*;

  logic [4:0] topo_size;
  logic       src_ok;
  logic       dst_ok;
  logic       slot_ok;
  cmd_t       kind;
  status_t    st;

  always_ff @(posedge clk) begin
    if (rst) begin
      topo_size <= '0;
    end else if (cfg_we) begin
      topo_size <= cfg_wdata;
    end
  end

  assign src_ok  = 9'(from_node) < 9'(NODES);
  assign dst_ok  = 9'(to_node) < 9'(NODES);
  assign slot_ok = 9'(slot) < 9'(WAYS);

  always_comb begin
    kind = cmd_t'(cmd);
    st   = ST_OK;
    case (cmd_t'(cmd))
      CMD_LOOKUP: begin
        if (topo_size == '0) begin
          st = ST_NOT_LOADED;
        end else if (!src_ok || !dst_ok || 5'(from_node) >= topo_size ||
                     5'(to_node) >= topo_size) begin
          st = ST_RANGE;
        end else if (from_node == to_node) begin
          st = ST_SAME_NODE;
        end
      end
      // drop writes that fall outside the table
      CMD_SLOT_WR: begin
        if (!(src_ok && dst_ok && slot_ok)) kind = CMD_NONE;
      end
      CMD_COUNT_WR: begin
        if (!(src_ok && dst_ok)) kind = CMD_NONE;
      end
      default: begin
        kind = CMD_NONE;
      end
    endcase
  end

  assign push = start && !busy;

  always_comb begin
    item.side.kind   = kind;
    item.side.status = st;
    item.side.src    = from_node;
    item.side.dst    = to_node;
    item.side.slot   = slot;
    item.side.iface  = hop_interface;
    item.count       = hop_count;
    item.w0          = src_ip;
    item.w1          = dst_ip;
    item.w2          = {flow_dport, flow_sport};
    item.seed        = seed;
  end

endmodule

>>> hw/rtl/ecmp_queue.sv
// ----------------------------------------------------------------------------
// ECMP item queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module ecmp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ecmp_pkg::fe_item_t item,
  output logic               full,
  output logic               head_valid,
  output ecmp_pkg::fe_item_t head
);
  import ecmp_pkg::*;

  fe_item_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) return '0;
    return p + QPTR_W'(1);
  endfunction

  assign head_valid = (count != '0);
  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  // the back end takes the head every cycle that the queue is not empty
  assign pop        = head_valid;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/ecmp_hash.sv
// ----------------------------------------------------------------------------
// ECMP flow hash
// Eight-stage MurmurHash3 x86_32 pipeline over a three-word key.
// ----------------------------------------------------------------------------
module ecmp_hash (
  input  logic        clk,
  input  logic [31:0] w0,
  input  logic [31:0] w1,
  input  logic [31:0] w2,
  input  logic [31:0] seed,
  output logic [31:0] h
);
  import ecmp_pkg::*;

  logic [31:0] key_mul1 [3];
  logic [31:0] key_mul2 [3];
  logic [31:0] seed1;
  logic [31:0] seed2;
  logic [31:0] acc3;
  logic [31:0] key3a;
  logic [31:0] key3b;
  logic [31:0] acc4;
  logic [31:0] key4;
  logic [31:0] acc5;
  logic [31:0] acc6;
  logic [31:0] acc7;
  logic [31:0] acc8;

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    return {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] mix_tail(input logic [31:0] a, input logic [31:0] k);
    logic [31:0] t;
    t = a ^ k;
    t = {t[18:0], t[31:19]};
    return (t << 2) + t + MUR_N;
  endfunction

  function automatic logic [31:0] fmix_head(input logic [31:0] a);
    logic [31:0] t;
    t = a ^ KEY_BYTES;
    return t ^ (t >> 16);
  endfunction

  always_ff @(posedge clk) begin
    key_mul1[0] <= w0 * MUR_C1;
    key_mul1[1] <= w1 * MUR_C1;
    key_mul1[2] <= w2 * MUR_C1;
    seed1       <= seed;
    for (int i = 0; i < 3; i++) begin
      key_mul2[i] <= rotl15(key_mul1[i]) * MUR_C2;
    end
    seed2 <= seed1;
    acc3  <= mix_tail(seed2, key_mul2[0]);
    key3a <= key_mul2[1];
    key3b <= key_mul2[2];
    acc4  <= mix_tail(acc3, key3a);
    key4  <= key3b;
    acc5  <= fmix_head(mix_tail(acc4, key4));
    acc6  <= acc5 * FMIX_C1;
    acc7  <= (acc6 ^ (acc6 >> 13)) * FMIX_C2;
    acc8  <= acc7 ^ (acc7 >> 16);
  end

  assign h = acc8;

endmodule

>>> hw/rtl/ecmp_mod.sv
// ----------------------------------------------------------------------------
// ECMP modulo unit
// Pipelined restoring remainder of a 32-bit hash by a small count.
// ----------------------------------------------------------------------------
module ecmp_mod #(
  parameter int CW = 4
) (
  input  logic          clk,
  input  logic [31:0]   h,
  input  logic [CW-1:0] n,
  output logic [CW-1:0] rem
);
  import ecmp_pkg::*;

  logic [CW-1:0] r_reg [MOD_STAGES];
  logic [31:0]   h_reg [MOD_STAGES-1];
  logic [CW-1:0] n_reg [MOD_STAGES-1];
  logic [31:0]   h_s   [MOD_STAGES];
  logic [CW-1:0] n_s   [MOD_STAGES];
  logic [CW-1:0] r_s   [MOD_STAGES];
  logic [CW-1:0] r_c   [MOD_STAGES];

  for (genvar s = 0; s < MOD_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign h_s[s] = h;
      assign n_s[s] = n;
      assign r_s[s] = '0;
    end else begin : g_rest
      assign h_s[s] = h_reg[s-1];
      assign n_s[s] = n_reg[s-1];
      assign r_s[s] = r_reg[s-1];
    end

    // one quotient bit per step, most significant first
    always_comb begin
      logic [CW:0]   t;
      logic [CW-1:0] r;
      r = r_s[s];
      for (int i = 0; i < MOD_BITS; i++) begin
        t = {r, h_s[s][31 - s * MOD_BITS - i]};
        if (t >= {1'b0, n_s[s]}) t = t - {1'b0, n_s[s]};
        r = t[CW-1:0];
      end
      r_c[s] = r;
    end

    always_ff @(posedge clk) begin
      r_reg[s] <= r_c[s];
    end

    if (s < MOD_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        h_reg[s] <= h_s[s];
        n_reg[s] <= n_s[s];
      end
    end
  end

  assign rem = r_reg[MOD_STAGES-1];

endmodule

>>> hw/rtl/ecmp_back.sv
// ----------------------------------------------------------------------------
// ECMP back end
// Route table, hash and modulo pipeline, slot read and result stage.
// ----------------------------------------------------------------------------
`include "ecmp_next_hop_select_unit_macros.svh"

module ecmp_back #(
  parameter int NODES = 16,
  parameter int WAYS  = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  ecmp_pkg::fe_item_t head,
  output logic               clearing,
  output logic               done,
  output logic [7:0]         out_interface,
  output logic [2:0]         status
);
  import ecmp_pkg::*;

  localparam int NIW        = $clog2(NODES);
  localparam int ROW_W      = 2 * NIW;
  localparam int ROW_DEPTH  = 1 << ROW_W;
  localparam int SW         = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW         = $clog2(WAYS + 1);
  localparam int SLOT_DEPTH = 1 << (ROW_W + SW);
  localparam int SIDE_LEN   = HASH_LAT + MOD_STAGES;
  localparam int OUT_LAT    = SIDE_LEN + 1;

  logic [CW-1:0]       cnt_mem  [ROW_DEPTH];
  logic [7:0]          slot_mem [SLOT_DEPTH];
  logic                clr_active;
  logic [ROW_W-1:0]    clr_idx;
  logic [ROW_W-1:0]    head_row;
  logic [CW-1:0]       cnt_rd;
  logic [SIDE_LEN:1]   vld;
  side_t               side   [1:SIDE_LEN];
  side_t               side2_next;
  logic [CW-1:0]       n_pipe [2:HASH_LAT];
  logic                vld_o;
  side_t               side_o;
  logic [31:0]         hash;
  logic [CW-1:0]       rem;
  logic [7:0]          idx8;
  logic [ROW_W+SW-1:0] slot_addr;
  logic [7:0]          slot_rd;

  function automatic logic [ROW_W-1:0] row_of(input logic [3:0] s, input logic [3:0] d);
    logic [8:0] s9;
    logic [8:0] d9;
    s9 = 9'(s);
    d9 = 9'(d);
    return {s9[NIW-1:0], d9[NIW-1:0]};
  endfunction

  function automatic logic [CW-1:0] sat_count(input logic [3:0] c);
    if (9'(c) > 9'(WAYS)) return CW'(WAYS);
    return CW'(c);
  endfunction

  // clearing pass over the hop counts after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      clr_idx <= clr_idx + ROW_W'(1);
      if (clr_idx == '1) clr_active <= 1'b0;
    end
  end

  assign clearing = clr_active;
  assign head_row = row_of(head.side.src, head.side.dst);

  always_ff @(posedge clk) begin
    if (clr_active) begin
      cnt_mem[clr_idx] <= '0;
    end else if (head_valid && head.side.kind == CMD_COUNT_WR) begin
      cnt_mem[head_row] <= sat_count(head.count);
    end
    cnt_rd <= cnt_mem[head_row];
  end

  ecmp_hash u_hash (
    .clk  (clk),
    .w0   (head.w0),
    .w1   (head.w1),
    .w2   (head.w2),
    .seed (head.seed),
    .h    (hash)
  );

  ecmp_mod #(
    .CW (CW)
  ) u_mod (
    .clk (clk),
    .h   (hash),
    .n   (n_pipe[HASH_LAT]),
    .rem (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_o <= 1'b0;
    end else begin
      vld   <= {vld[SIDE_LEN-1:1], head_valid};
      vld_o <= vld[SIDE_LEN];
    end
  end

  // empty row: no route
  always_comb begin
    side2_next = side[1];
    if (side[1].kind == CMD_LOOKUP && side[1].status == ST_OK && cnt_rd == '0) begin
      side2_next.status = ST_NO_ROUTE;
    end
  end

  always_ff @(posedge clk) begin
    side[1] <= head.side;
    side[2] <= side2_next;
    for (int s = 3; s <= SIDE_LEN; s++) begin
      side[s] <= side[s-1];
    end
    side_o    <= side[SIDE_LEN];
    n_pipe[2] <= cnt_rd;
    for (int s = 3; s <= HASH_LAT; s++) begin
      n_pipe[s] <= n_pipe[s-1];
    end
  end

  assign idx8      = (side[SIDE_LEN].kind == CMD_LOOKUP) ? 8'(rem) : 8'(side[SIDE_LEN].slot);
  assign slot_addr = {row_of(side[SIDE_LEN].src, side[SIDE_LEN].dst), idx8[SW-1:0]};

  always_ff @(posedge clk) begin
    if (vld[SIDE_LEN] && side[SIDE_LEN].kind == CMD_SLOT_WR) begin
      slot_mem[slot_addr] <= side[SIDE_LEN].iface;
    end
    slot_rd <= slot_mem[slot_addr];
  end

  assign done          = vld_o;
  assign status        = side_o.status;
  assign out_interface = (side_o.kind == CMD_LOOKUP && side_o.status == ST_OK) ? slot_rd : '0;

  `ECMP_ASSERT(a_no_pop_in_clear, clk, rst, clr_active, !head_valid)
  `ECMP_ASSERT(a_fixed_latency, clk, rst, head_valid, ##OUT_LAT vld_o)
  `ECMP_ASSERT(a_err_zero_iface, clk, rst, vld_o && side_o.status != ST_OK, out_interface == '0)
  `ECMP_ASSERT_NEXT(a_write_ok, clk, rst, vld[SIDE_LEN] && side[SIDE_LEN].kind != CMD_LOOKUP, vld_o && side_o.status == ST_OK)

endmodule

>>> verif/ecmp_next_hop_select_unit_tb.sv
// ----------------------------------------------------------------------------
// ECMP next-hop select unit testbench
// Drives route table writes and flow lookups into the select unit, predicts
// each answer with a local route table and MurmurHash3 flow hash, and checks
// every done strobe against the oldest pending answer, across several
// topology sizes and sender idle rates.
// ----------------------------------------------------------------------------
module ecmp_next_hop_select_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ecmp_pkg::*;

  localparam int TB_NODES    = 16;
  localparam int TB_WAYS     = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 48;

  typedef struct {
    cmd_t        op;
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seed;
    logic [2:0]  slot;
    logic [7:0]  iface;
    logic [3:0]  count;
  } hop_req_t;

  typedef struct {
    logic [7:0] ifc;
    status_t    st;
  } hop_ans_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic [1:0]  cmd = '0;
  logic [3:0]  from_node = '0;
  logic [3:0]  to_node = '0;
  logic [31:0] src_ip = '0;
  logic [31:0] dst_ip = '0;
  logic [15:0] flow_sport = '0;
  logic [15:0] flow_dport = '0;
  logic [31:0] seed = '0;
  logic [2:0]  slot = '0;
  logic [7:0]  hop_interface = '0;
  logic [3:0]  hop_count = '0;
  logic        done;
  logic [7:0]  out_interface;
  logic [2:0]  status;

  ecmp_next_hop_select_unit #(
    .NODES(TB_NODES),
    .WAYS (TB_WAYS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .from_node    (from_node),
    .to_node      (to_node),
    .src_ip       (src_ip),
    .dst_ip       (dst_ip),
    .flow_sport   (flow_sport),
    .flow_dport   (flow_dport),
    .seed         (seed),
    .slot         (slot),
    .hop_interface(hop_interface),
    .hop_count    (hop_count),
    .done         (done),
    .out_interface(out_interface),
    .status       (status)
  );

  // Requests waiting for the driver, answers waiting for a done strobe
  hop_req_t req_q[$];
  hop_ans_t answer_q[$];
  hop_req_t drv_item;
  int       send_idle_pct = 0;

  // Predictor copy of the route table, updated as items are accepted
  logic [7:0] tbl_iface [256][TB_WAYS];
  logic [3:0] tbl_count [256];
  logic [4:0] tbl_nodes;

  // Generator shadow: which slots are written, so no lookup reads a blank one
  bit         gen_written [256][TB_WAYS];
  logic [3:0] gen_count [256];
  logic [4:0] gen_nodes;

  int cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  int hashed_hits = 0;
  int status_seen [5];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers pending", cycles, answer_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] flow_hash(input hop_req_t r);
    logic [31:0] h;
    logic [31:0] k;
    logic [31:0] key [3];
    key[0] = r.sip;
    key[1] = r.dip;
    key[2] = {r.dport, r.sport};
    h = r.seed;
    for (int i = 0; i < 3; i++) begin
      k = key[i] * MUR_C1;
      k = rotl(k, 15);
      k = k * MUR_C2;
      h = h ^ k;
      h = rotl(h, 13);
      h = h * 32'd5 + MUR_N;
    end
    h = h ^ KEY_BYTES;
    h = h ^ (h >> 16);
    h = h * FMIX_C1;
    h = h ^ (h >> 13);
    h = h * FMIX_C2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic status_t route_status(input logic [4:0] nodes, input logic [3:0] n,
                                           input logic [3:0] s, input logic [3:0] d);
    int lim;
    lim = (nodes < TB_NODES) ? nodes : TB_NODES;
    if (nodes == 0) return ST_NOT_LOADED;
    if (s >= lim || d >= lim) return ST_RANGE;
    if (s == d) return ST_SAME_NODE;
    if (n == 0) return ST_NO_ROUTE;
    return ST_OK;
  endfunction

  // Slot a lookup reads from a row holding n hops
  function automatic int way_of(input logic [3:0] n, input hop_req_t r);
    logic [31:0] m;
    if (n == 1) return 0;
    m = flow_hash(r) % {28'd0, n};
    return int'(m);
  endfunction

  function automatic void predict_hop(input hop_req_t r, output hop_ans_t a);
    logic [7:0] row;
    int w;
    row = {r.src, r.dst};
    a.ifc = '0;
    a.st = ST_OK;
    case (r.op)
      CMD_SLOT_WR: tbl_iface[row][r.slot] = r.iface;
      CMD_COUNT_WR: tbl_count[row] = (r.count > TB_WAYS) ? 4'(TB_WAYS) : r.count;
      CMD_LOOKUP: begin
        a.st = route_status(tbl_nodes, tbl_count[row], r.src, r.dst);
        if (a.st == ST_OK) begin
          w = way_of(tbl_count[row], r);
          a.ifc = tbl_iface[row][w];
        end
      end
      default: ;
    endcase
  endfunction

  function automatic hop_req_t any_req(input cmd_t op);
    hop_req_t r;
    r.op = op;
    r.src = 4'($urandom_range(15));
    r.dst = 4'($urandom_range(15));
    r.sip = $urandom;
    r.dip = $urandom;
    r.sport = 16'($urandom_range(65535));
    r.dport = 16'($urandom_range(65535));
    r.seed = $urandom;
    r.slot = 3'($urandom_range(7));
    r.iface = 8'($urandom_range(255));
    r.count = 4'($urandom_range(15));
    return r;
  endfunction

  // Aim at a pair of distinct nodes inside the loaded topology when possible
  function automatic void aim_pair(inout hop_req_t r);
    int lim;
    lim = (gen_nodes < TB_NODES) ? gen_nodes : TB_NODES;
    if (lim < 2) return;
    r.src = 4'($urandom_range(lim - 1));
    r.dst = 4'(($urandom_range(1, lim - 1) + r.src) % lim);
  endfunction

  function automatic void push_item(input hop_req_t r);
    logic [7:0] row;
    row = {r.src, r.dst};
    if (r.op == CMD_SLOT_WR) gen_written[row][r.slot] = 1'b1;
    if (r.op == CMD_COUNT_WR) gen_count[row] = (r.count > TB_WAYS) ? 4'(TB_WAYS) : r.count;
    req_q.insert(req_q.size(), r);
  endfunction

  // Fill the slot a lookup will read first if it was never written
  function automatic void push_lookup(input hop_req_t r);
    logic [7:0] row;
    hop_req_t wr;
    int w;
    row = {r.src, r.dst};
    if (route_status(gen_nodes, gen_count[row], r.src, r.dst) == ST_OK) begin
      w = way_of(gen_count[row], r);
      if (!gen_written[row][w]) begin
        wr = any_req(CMD_SLOT_WR);
        wr.src = r.src;
        wr.dst = r.dst;
        wr.slot = 3'(w);
        push_item(wr);
      end
    end
    push_item(r);
  endfunction

  task automatic set_nodes(input logic [4:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= 5'($urandom_range(31));
    gen_nodes = v;
  endtask

  task automatic wait_drained;
    do @(negedge clk); while (req_q.size() != 0 || start || answer_q.size() != 0);
  endtask

  // Driver: present the next item once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || busy === 1'b0) begin
      if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = req_q.pop_front();
        start <= 1'b1;
        cmd <= drv_item.op;
        from_node <= drv_item.src;
        to_node <= drv_item.dst;
        src_ip <= drv_item.sip;
        dst_ip <= drv_item.dip;
        flow_sport <= drv_item.sport;
        flow_dport <= drv_item.dport;
        seed <= drv_item.seed;
        slot <= drv_item.slot;
        hop_interface <= drv_item.iface;
        hop_count <= drv_item.count;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check strobed results, then predict the item taken this edge
  hop_req_t mon_req;
  hop_ans_t mon_want;
  hop_ans_t mon_next;

  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: if=%02h st=%0d", out_interface, status);
        end else begin
          mon_want = answer_q.pop_front();
          if (out_interface !== mon_want.ifc || status !== mon_want.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected if=%02h st=%0d, got if=%02h st=%0d",
                       mon_want.ifc, mon_want.st, out_interface, status);
          end
        end
      end
      if (start && busy === 1'b0) begin
        mon_req.op = cmd_t'(cmd);
        mon_req.src = from_node;
        mon_req.dst = to_node;
        mon_req.sip = src_ip;
        mon_req.dip = dst_ip;
        mon_req.sport = flow_sport;
        mon_req.dport = flow_dport;
        mon_req.seed = seed;
        mon_req.slot = slot;
        mon_req.iface = hop_interface;
        mon_req.count = hop_count;
        predict_hop(mon_req, mon_next);
        if (mon_req.op == CMD_LOOKUP) begin
          status_seen[mon_next.st]++;
          if (mon_next.st == ST_OK && tbl_count[{mon_req.src, mon_req.dst}] > 1)
            hashed_hits++;
        end
        answer_q.insert(answer_q.size(), mon_next);
      end
      if (cfg_we) tbl_nodes = cfg_wdata;
    end
  end

  initial begin
    hop_req_t r;
    hop_req_t row_req;
    int pick;
    int n;
    logic [4:0] phase_nodes [PHASES];
    int phase_idle [PHASES];

    phase_nodes = '{5'd16, 5'd5, 5'd2, 5'd1, 5'd16, 5'd0, 5'd11, 5'd16};
    phase_idle = '{0, 48, 0, 8, 48, 0, 8, 0};
    for (int i = 0; i < 256; i++) begin
      tbl_count[i] = '0;
      gen_count[i] = '0;
      for (int w = 0; w < TB_WAYS; w++) begin
        tbl_iface[i][w] = '0;
        gen_written[i][w] = 1'b0;
      end
    end
    for (int i = 0; i < 5; i++) status_seen[i] = 0;
    tbl_nodes = '0;
    gen_nodes = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // hold off until the hop count clearing pass finishes
    do @(negedge clk); while (busy !== 1'b0);

    // Directed: topology not loaded yet
    push_lookup(any_req(CMD_LOOKUP));
    wait_drained();
    set_nodes(5'd16);

    // one-hop row answers its only slot directly
    r = any_req(CMD_COUNT_WR);
    r.src = 4'd0; r.dst = 4'd1; r.count = 4'd1;
    push_item(r);
    r = any_req(CMD_SLOT_WR);
    r.src = 4'd0; r.dst = 4'd1; r.slot = 3'd0; r.iface = 8'hff;
    push_item(r);
    r = any_req(CMD_LOOKUP);
    r.src = 4'd0; r.dst = 4'd1;
    push_lookup(r);

    // oversized count saturates to a full row
    r = any_req(CMD_COUNT_WR);
    r.src = 4'd15; r.dst = 4'd14; r.count = 4'hf;
    push_item(r);
    for (int w = 0; w < TB_WAYS; w++) begin
      r = any_req(CMD_SLOT_WR);
      r.src = 4'd15; r.dst = 4'd14; r.slot = 3'(w); r.iface = 8'(w * 36);
      push_item(r);
    end
    r = any_req(CMD_LOOKUP);
    r.src = 4'd15; r.dst = 4'd14;
    r.sip = '1; r.dip = '1; r.sport = '1; r.dport = '1; r.seed = '1;
    push_lookup(r);
    r.sip = '0; r.dip = '0; r.sport = '0; r.dport = '0; r.seed = '0;
    push_lookup(r);

    // same node, empty row, unused command, row cleared back to zero
    r = any_req(CMD_LOOKUP);
    r.src = 4'd15; r.dst = 4'd15;
    push_lookup(r);
    r = any_req(CMD_LOOKUP);
    r.src = 4'd2; r.dst = 4'd3;
    push_lookup(r);
    r = any_req(CMD_NONE);
    r.src = '1; r.dst = '1; r.slot = '1; r.iface = '1; r.count = '1;
    push_item(r);
    r = any_req(CMD_COUNT_WR);
    r.src = 4'd0; r.dst = 4'd1; r.count = 4'd0;
    push_item(r);
    r = any_req(CMD_LOOKUP);
    r.src = 4'd0; r.dst = 4'd1;
    push_lookup(r);
    wait_drained();

    // Random phases, each under its own topology size and sender idle rate
    for (int p = 0; p < PHASES; p++) begin
      set_nodes(phase_nodes[p]);
      send_idle_pct = phase_idle[p];
      @(negedge clk);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          // program a row's hop count and all its slots, then let later lookups hash across it
          r = any_req(CMD_COUNT_WR);
          aim_pair(r);
          n = $urandom_range(1, TB_WAYS);
          r.count = 4'(n);
          push_item(r);
          row_req = r;
          for (int w = 0; w < n; w++) begin
            r = any_req(CMD_SLOT_WR);
            r.src = row_req.src;
            r.dst = row_req.dst;
            r.slot = 3'(w);
            push_item(r);
          end
        end else if (pick < 60) begin
          r = any_req(CMD_LOOKUP);
          aim_pair(r);
          push_lookup(r);
        end else if (pick < 70) begin
          push_lookup(any_req(CMD_LOOKUP));
        end else if (pick < 80) begin
          r = any_req(CMD_SLOT_WR);
          if ($urandom_range(3) != 0) aim_pair(r);
          push_item(r);
        end else if (pick < 90) begin
          r = any_req(CMD_COUNT_WR);
          aim_pair(r);
          if ($urandom_range(3) != 0) r.count = 4'($urandom_range(2, TB_WAYS));
          push_item(r);
        end else begin
          push_item(any_req(CMD_NONE));
        end
      end
      wait_drained();
    end

    // drain: let any stray strobe surface past the pipeline latency
    repeat (20) @(posedge clk);
    if (answer_q.size() != 0) mismatches += answer_q.size();

    $display("checked %0d results; lookups: ok %0d (%0d hashed), not loaded %0d,",
             results_seen, status_seen[ST_OK], hashed_hits, status_seen[ST_NOT_LOADED]);
    $display("  out of range %0d, same node %0d, no route %0d; %0d topology sizes",
             status_seen[ST_RANGE], status_seen[ST_SAME_NODE], status_seen[ST_NO_ROUTE],
             PHASES + 1);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
